FILE: rtl/ncc_pkg.sv
// Shared constants and types for the NCC score normalizer.
package ncc_pkg;

  localparam int unsigned CORR_W   = 30;
  localparam int unsigned WSUM_W   = 20;
  localparam int unsigned MEAN_W   = 16;
  localparam int unsigned NORM_W   = 22;
  localparam int unsigned INVA_W   = 25;
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 25;
  localparam int unsigned NCH      = 4;

  // sqrt iterations (one result bit per stage) and quotient bits
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 15;
  // start edge to strobe edge
  localparam int unsigned LATENCY    = 5 + SQRT_STEPS + 2 + DIV_STEPS + 1;

  localparam logic signed [SCORE_W-1:0] SCORE_ONE = 16'sd16384;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEAN0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVA  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT  = 3'd6;

  // side data riding along the sqrt stages
  typedef struct packed {
    logic        flat;
    logic        neg;
    logic        dz;
    logic [37:0] mag;
  } side_t;

  // side data riding along the divider stages
  typedef struct packed {
    logic flat;
    logic neg;
    logic lt;
    logic near;
  } dside_t;

endpackage

FILE: rtl/ncc_score_normalizer.sv
// Top level: pipelined NCC score normalizer.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i        | write when cfg_we_i high
//  item in  | correlation_i, win_sum_c*_i, win_square | start_i & !busy_o
//  result   | score_o                                 | valid_o, one cycle
//
// One item enters per cycle; busy_o is never raised. Each score passes
// through 5 front stages (products, sums, numerator/variance), 32 square-root
// stages (one root bit each), one multiply stage, one compare stage,
// 15 divider stages and one output stage.
// Reset clears the valid bits of every stage and loads register defaults.
// The receiver cannot stall, so nothing is held back.
module ncc_score_normalizer import ncc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [CORR_W-1:0]     correlation_i,
  input  logic [WSUM_W-1:0]     win_sum_c0_i,
  input  logic [WSUM_W-1:0]     win_sum_c1_i,
  input  logic [WSUM_W-1:0]     win_sum_c2_i,
  input  logic [WSUM_W-1:0]     win_sum_c3_i,
  input  logic [CORR_W-1:0]     win_square_sum_i,
  output logic                  valid_o,
  output logic signed [SCORE_W-1:0] score_o
);

  // ---------------- configuration registers
  logic [MEAN_W-1:0] mean_q [NCH];
  logic [NORM_W-1:0] norm_q;
  logic [INVA_W-1:0] inva_q;
  logic              flat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCH; c++) mean_q[c] <= '0;
      norm_q <= '0;
      inva_q <= 25'h100_0000;
      flat_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MEAN0: mean_q[0] <= cfg_wdata_i[MEAN_W-1:0];
        REG_MEAN1: mean_q[1] <= cfg_wdata_i[MEAN_W-1:0];
        REG_MEAN2: mean_q[2] <= cfg_wdata_i[MEAN_W-1:0];
        REG_MEAN3: mean_q[3] <= cfg_wdata_i[MEAN_W-1:0];
        REG_NORM:  norm_q    <= cfg_wdata_i[NORM_W-1:0];
        REG_INVA:  inva_q    <= cfg_wdata_i;
        REG_FLAT:  flat_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic [WSUM_W-1:0] ws [NCH];
  assign ws[0] = win_sum_c0_i;
  assign ws[1] = win_sum_c1_i;
  assign ws[2] = win_sum_c2_i;
  assign ws[3] = win_sum_c3_i;

  // ---------------- stage 1: per-channel products
  logic              v1_q, flat1_q;
  logic [29:0]       corr1_q, sq1_q;
  logic [35:0]       pd1_q [NCH];
  logic [39:0]       ps1_q [NCH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    flat1_q <= flat_q | (norm_q == '0);
    corr1_q <= correlation_i;
    sq1_q   <= win_square_sum_i;
    for (int c = 0; c < NCH; c++) begin
      pd1_q[c] <= ws[c] * mean_q[c];
      ps1_q[c] <= ws[c] * ws[c];
    end
  end

  // ---------------- stage 2: channel sums
  logic        v2_q, flat2_q;
  logic [29:0] corr2_q, sq2_q;
  logic [37:0] dot2_q;
  logic [41:0] sumsq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    flat2_q  <= flat1_q;
    corr2_q  <= corr1_q;
    sq2_q    <= sq1_q;
    dot2_q   <= 38'(pd1_q[0]) + 38'(pd1_q[1]) + 38'(pd1_q[2]) + 38'(pd1_q[3]);
    sumsq2_q <= 42'(ps1_q[0]) + 42'(ps1_q[1]) + 42'(ps1_q[2]) + 42'(ps1_q[3]);
  end

  // ---------------- stage 3: numerator magnitude, mean-square products
  logic        v3_q, flat3_q, neg3_q;
  logic [29:0] sq3_q;
  logic [37:0] mag3_q;
  logic [53:0] phi3_q;
  logic [54:0] plo3_q;
  logic [37:0] pos2;

  assign pos2 = {corr2_q, 8'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    flat3_q <= flat2_q;
    sq3_q   <= sq2_q;
    neg3_q  <= pos2 < dot2_q;
    mag3_q  <= (pos2 < dot2_q) ? dot2_q - pos2 : pos2 - dot2_q;
    phi3_q  <= sumsq2_q * inva_q[24:13];
    plo3_q  <= sumsq2_q * inva_q[12:0];
  end

  // ---------------- stage 4: variance term and threshold
  logic        v4_q, flat4_q, neg4_q;
  logic [37:0] mag4_q;
  logic [53:0] diff4_q;
  logic [23:0] thr4_q;
  logic [55:0] mean2_3;
  logic [53:0] sq24_3;
  logic [34:0] thr_raw3;

  assign mean2_3  = {2'b0, phi3_q[40:0], 13'b0} + {1'b0, plo3_q};
  assign sq24_3   = {sq3_q, 24'b0};
  assign thr_raw3 = 35'(sq3_q) * 35'd20;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    flat4_q <= flat3_q;
    neg4_q  <= neg3_q;
    mag4_q  <= mag3_q;
    if (phi3_q[53:41] != '0 || {2'b0, sq24_3} <= mean2_3) diff4_q <= '0;
    else diff4_q <= sq24_3 - mean2_3[53:0];
    thr4_q  <= (thr_raw3 > 35'h80_0000) ? 24'h80_0000 : thr_raw3[23:0];
  end

  // ---------------- stage 5 (sqrt stage 0 input): tiny-variance flag
  logic        sv_q  [SQRT_STEPS+1];
  side_t       ss_q  [SQRT_STEPS+1];
  logic [63:0] rem_q [SQRT_STEPS+1];
  logic [63:0] res_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else         sv_q[0] <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    ss_q[0].flat <= flat4_q;
    ss_q[0].neg  <= neg4_q;
    ss_q[0].mag  <= mag4_q;
    ss_q[0].dz   <= diff4_q <= 54'(thr4_q);
    rem_q[0]     <= {2'b0, diff4_q, 8'b0};
    res_q[0]     <= '0;
  end

  // ---------------- square root: one root bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;

    assign trial = res_q[k] + BIT;
    assign take  = rem_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else         sv_q[k+1] <= sv_q[k];
    end

    always_ff @(posedge clk_i) begin
      ss_q[k+1]  <= ss_q[k];
      rem_q[k+1] <= take ? rem_q[k] - trial : rem_q[k];
      res_q[k+1] <= take ? (res_q[k] >> 1) + BIT : res_q[k] >> 1;
    end
  end

  // ---------------- denominator = root * norm
  logic        vm_q;
  side_t       sm_q;
  logic [52:0] denm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else         vm_q <= sv_q[SQRT_STEPS];
  end

  always_ff @(posedge clk_i) begin
    sm_q   <= ss_q[SQRT_STEPS];
    denm_q <= ss_q[SQRT_STEPS].dz ? '0 : res_q[SQRT_STEPS][30:0] * norm_q;
  end

  // ---------------- compare stage, feeds divider
  logic        dv_q [DIV_STEPS+1];
  dside_t      ds_q [DIV_STEPS+1];
  logic [54:0] r_q  [DIV_STEPS+1];
  logic [14:0] q_q  [DIV_STEPS+1];
  logic [52:0] d_q  [DIV_STEPS+1];
  logic [53:0] magm;

  assign magm = {sm_q.mag, 16'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else         dv_q[0] <= vm_q;
  end

  always_ff @(posedge clk_i) begin
    ds_q[0].flat <= sm_q.flat;
    ds_q[0].neg  <= sm_q.neg;
    ds_q[0].lt   <= magm < {1'b0, denm_q};
    ds_q[0].near <= {magm, 3'b0} < ({1'b0, denm_q, 3'b0} + 57'(denm_q));
    r_q[0]       <= {1'b0, magm};
    q_q[0]       <= '0;
    d_q[0]       <= denm_q;
  end

  // ---------------- restoring divider: one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [54:0] sh;
    logic        ge;

    assign sh = {r_q[j][53:0], 1'b0};
    assign ge = sh >= {2'b0, d_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j+1] <= 1'b0;
      else         dv_q[j+1] <= dv_q[j];
    end

    always_ff @(posedge clk_i) begin
      ds_q[j+1] <= ds_q[j];
      d_q[j+1]  <= d_q[j];
      r_q[j+1]  <= ge ? sh - {2'b0, d_q[j]} : sh;
      q_q[j+1]  <= {q_q[j][13:0], ge};
    end
  end

  // ---------------- output: round half away, apply sign, special cases
  dside_t      dl;
  logic [15:0] qr;
  logic signed [SCORE_W-1:0] score_d;

  assign dl = ds_q[DIV_STEPS];
  assign qr = (16'(q_q[DIV_STEPS]) + 16'd1) >> 1;

  always_comb begin
    if (dl.flat)      score_d = SCORE_ONE;
    else if (dl.lt)   score_d = dl.neg ? -$signed(qr) : $signed(qr);
    else if (dl.near) score_d = dl.neg ? -SCORE_ONE : SCORE_ONE;
    else              score_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= dv_q[DIV_STEPS];
  end

  always_ff @(posedge clk_i) begin
    score_o <= score_d;
  end

endmodule

FILE: rtl/ncc_checker.sv
// Port-level checker for the NCC score normalizer, bound to the top level.
module ncc_checker import ncc_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      valid_o,
  input logic signed [SCORE_W-1:0] score_o
);

  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY valid_o)
    else $error("item start not followed by score strobe");

  a_lat_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, LATENCY))
    else $error("score strobe without matching start");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (score_o <= SCORE_ONE && score_o >= -SCORE_ONE))
    else $error("score outside +-1.0");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

endmodule

bind ncc_score_normalizer ncc_checker u_ncc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .valid_o (valid_o),
  .score_o (score_o)
);
